[rtl/core/stok_pkg.sv]
`timescale 1ns / 1ps
// Shared types, token kind codes and character tables for the source tokenizer.
// No dependencies; used by stok_lexer, stok_fifo and source_tokenizer.
package stok_pkg;

	// Token kinds in emission code order
	typedef enum logic [5:0] {
		KIND_UNKNOWN, KIND_EOF, KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV,
		KIND_INC, KIND_DEC, KIND_ASSIGN, KIND_IDENT, KIND_INTEGER, KIND_DECIMAL,
		KIND_LBRACE, KIND_RBRACE, KIND_LBRACKET, KIND_RBRACKET, KIND_LPAREN,
		KIND_RPAREN, KIND_VAR, KIND_TRUE, KIND_FALSE, KIND_IF, KIND_ELSE,
		KIND_WHILE, KIND_BREAK, KIND_RETURN, KIND_FN, KIND_SEMI, KIND_LT,
		KIND_LE, KIND_GT, KIND_GE, KIND_EQ, KIND_NE, KIND_NOT, KIND_AND,
		KIND_OR, KIND_COMMA
	} kind_t;

	localparam logic [15:0] LEN_MAX     = 16'hFFFF;
	localparam int          KW_COUNT    = 9;
	localparam int          KW_TEXT_MAX = 6;
	localparam logic [3:0]  PAIR_COUNT  = 4'd8;
	localparam logic [7:0]  CH_LF       = 8'h0A;
	localparam logic [7:0]  CH_CR       = 8'h0D;
	localparam logic [7:0]  CH_TAB      = 8'h09;
	localparam logic [7:0]  CH_SPACE    = 8'h20;

	// One result token
	typedef struct packed {
		kind_t       kind;
		logic [15:0] begin_line;
		logic [15:0] begin_column;
		logic [15:0] end_line;
		logic [15:0] end_column;
		logic [15:0] length;
		logic        last;
	} token_t;

	// Tokens produced by one input transfer
	typedef struct packed {
		logic [1:0] count;
		token_t     first;
		token_t     second;
	} lex_out_t;

	typedef struct packed {
		logic [7:0] first;
		logic [7:0] second;
		kind_t      alone;
		kind_t      both;
	} pair_t;

	typedef struct packed {
		logic       hit;
		logic [2:0] idx;
	} pair_hit_t;

	typedef struct packed {
		logic [KW_TEXT_MAX-1:0][7:0] text;
		logic [2:0]                  len;
		kind_t                       kind;
	} kw_entry_t;

	// Operators that may pair with a following character
	function automatic pair_t pair_entry(input logic [2:0] idx);
		pair_t p;
		unique case (idx)
			3'd0: p = '{first: "+", second: "+", alone: KIND_ADD,     both: KIND_INC};
			3'd1: p = '{first: "-", second: "-", alone: KIND_SUB,     both: KIND_DEC};
			3'd2: p = '{first: "<", second: "=", alone: KIND_LT,      both: KIND_LE};
			3'd3: p = '{first: ">", second: "=", alone: KIND_GT,      both: KIND_GE};
			3'd4: p = '{first: "=", second: "=", alone: KIND_ASSIGN,  both: KIND_EQ};
			3'd5: p = '{first: "!", second: "=", alone: KIND_NOT,     both: KIND_NE};
			3'd6: p = '{first: "&", second: "&", alone: KIND_UNKNOWN, both: KIND_AND};
			3'd7: p = '{first: "|", second: "|", alone: KIND_UNKNOWN, both: KIND_OR};
		endcase
		return p;
	endfunction

	// Find the pair operator that a character opens
	function automatic pair_hit_t pair_find(input logic [7:0] c);
		pair_hit_t r;
		r = '{hit: 1'b1, idx: 3'd0};
		unique case (c)
			"+": r.idx = 3'd0;
			"-": r.idx = 3'd1;
			"<": r.idx = 3'd2;
			">": r.idx = 3'd3;
			"=": r.idx = 3'd4;
			"!": r.idx = 3'd5;
			"&": r.idx = 3'd6;
			"|": r.idx = 3'd7;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	// Single-character tokens; anything else is unknown
	function automatic kind_t single_kind(input logic [7:0] c);
		kind_t k;
		unique case (c)
			"*": k = KIND_MUL;
			"/": k = KIND_DIV;
			"(": k = KIND_LPAREN;
			")": k = KIND_RPAREN;
			"[": k = KIND_LBRACKET;
			"]": k = KIND_RBRACKET;
			"{": k = KIND_LBRACE;
			"}": k = KIND_RBRACE;
			";": k = KIND_SEMI;
			",": k = KIND_COMMA;
			default: k = KIND_UNKNOWN;
		endcase
		return k;
	endfunction

	// Keyword table, first character in byte 0
	function automatic kw_entry_t kw_entry(input logic [3:0] idx);
		kw_entry_t e;
		unique case (idx)
			4'd0: e = '{text: {8'h0, 8'h0, 8'h0, "r", "a", "v"}, len: 3'd3, kind: KIND_VAR};
			4'd1: e = '{text: {8'h0, 8'h0, "e", "u", "r", "t"}, len: 3'd4, kind: KIND_TRUE};
			4'd2: e = '{text: {8'h0, "e", "s", "l", "a", "f"}, len: 3'd5, kind: KIND_FALSE};
			4'd3: e = '{text: {8'h0, 8'h0, 8'h0, 8'h0, "f", "i"}, len: 3'd2, kind: KIND_IF};
			4'd4: e = '{text: {8'h0, 8'h0, "e", "s", "l", "e"}, len: 3'd4, kind: KIND_ELSE};
			4'd5: e = '{text: {8'h0, "e", "l", "i", "h", "w"}, len: 3'd5, kind: KIND_WHILE};
			4'd6: e = '{text: {8'h0, "k", "a", "e", "r", "b"}, len: 3'd5, kind: KIND_BREAK};
			4'd7: e = '{text: {8'h0, 8'h0, 8'h0, 8'h0, "n", "f"}, len: 3'd2, kind: KIND_FN};
			4'd8: e = '{text: {"n", "r", "u", "t", "e", "r"}, len: 3'd6, kind: KIND_RETURN};
			default: e = '{text: '0, len: 3'd0, kind: KIND_IDENT};
		endcase
		return e;
	endfunction

endpackage

[rtl/core/stok_lexer.sv]
`timescale 1ns / 1ps
// Lexer state and per-character token decision for the source tokenizer.
// Depends on stok_pkg for token types, kinds and character tables.
module stok_lexer #(
	parameter int KEYWORD_MAX_LEN = 6,
	parameter int POSITION_WIDTH  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         char_code,
	input  logic               end_of_input,
	output stok_pkg::lex_out_t res
);

	localparam int WLEN_W = $clog2(KEYWORD_MAX_LEN + 1);
	localparam int WIDX_W = $clog2(KEYWORD_MAX_LEN);
	localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

	typedef enum logic [2:0] {
		MODE_IDLE, MODE_INT, MODE_DEC, MODE_WORD, MODE_PAIR, MODE_DONE
	} mode_t;

	mode_t                     mode_q, mode_d;
	logic [3:0]                pend_q, pend_d;
	stok_pkg::kind_t           held_q, held_d;
	logic [WLEN_W-1:0]         wlen_q, wlen_d;
	logic [POSITION_WIDTH-1:0] line_q, line_d;
	logic [POSITION_WIDTH-1:0] col_q, col_d;
	logic [POSITION_WIDTH-1:0] sline_q, sline_d;
	logic [POSITION_WIDTH-1:0] scol_q, scol_d;
	logic [15:0]               tlen_q, tlen_d;
	logic [7:0]                prefix_q [KEYWORD_MAX_LEN];

	logic                      pw_en;
	logic [WIDX_W-1:0]         pw_addr;

	logic                      is_digit, is_alpha, is_space, is_word;
	logic [POSITION_WIDTH-1:0] line_inc, col_inc;
	stok_pkg::kind_t           word_k, pend_k;
	stok_pkg::pair_t           pp;
	logic                      pv;
	stok_pkg::pair_hit_t       ph;
	stok_pkg::token_t          pend_tok, eof_tok;

	// Classify the incoming character
	always_comb begin
		is_digit = (char_code >= "0") && (char_code <= "9");
		is_alpha = ((char_code >= "a") && (char_code <= "z")) ||
			((char_code >= "A") && (char_code <= "Z"));
		is_space = (char_code == stok_pkg::CH_SPACE) || (char_code == stok_pkg::CH_TAB) ||
			(char_code == stok_pkg::CH_CR) || (char_code == stok_pkg::CH_LF);
		is_word  = is_alpha || is_digit || (char_code == "_");
		ph       = stok_pkg::pair_find(char_code);
	end

	// Saturating position increments
	assign line_inc = (line_q != POS_MAX) ? line_q + 1'b1 : line_q;
	assign col_inc  = (col_q != POS_MAX) ? col_q + 1'b1 : col_q;

	// Match the held word prefix against the keyword table; earliest entry wins
	always_comb begin
		stok_pkg::kw_entry_t kw;
		logic hit;
		word_k = stok_pkg::KIND_IDENT;
		for (int i = stok_pkg::KW_COUNT - 1; i >= 0; i--) begin
			kw  = stok_pkg::kw_entry(4'(i));
			hit = (tlen_q == 16'(kw.len)) && (WLEN_W'(kw.len) <= wlen_q);
			for (int j = 0; j < stok_pkg::KW_TEXT_MAX; j++) begin
				if ((3'(j) < kw.len) && (prefix_q[j] != kw.text[j]))
					hit = 1'b0;
			end
			if (hit)
				word_k = kw.kind;
		end
	end

	// Kind of the token currently being scanned
	assign pv = (pend_q != 4'd0) && (pend_q <= stok_pkg::PAIR_COUNT);
	assign pp = stok_pkg::pair_entry(3'(pend_q - 4'd1));

	always_comb begin
		unique case (mode_q)
			MODE_INT:  pend_k = stok_pkg::KIND_INTEGER;
			MODE_DEC:  pend_k = stok_pkg::KIND_DECIMAL;
			MODE_WORD: pend_k = word_k;
			MODE_PAIR: pend_k = pv ? pp.alone : stok_pkg::KIND_UNKNOWN;
			MODE_DONE: pend_k = held_q;
			default:   pend_k = stok_pkg::KIND_UNKNOWN;
		endcase
	end

	// Advance state and build the tokens of this transfer
	always_comb begin
		logic ext;
		mode_t ext_mode;
		logic [POSITION_WIDTH-1:0] nl, nc;

		mode_d  = mode_q;
		pend_d  = pend_q;
		held_d  = held_q;
		wlen_d  = wlen_q;
		line_d  = line_q;
		col_d   = col_q;
		sline_d = sline_q;
		scol_d  = scol_q;
		tlen_d  = tlen_q;
		pw_en   = 1'b0;
		pw_addr = '0;
		res     = '0;

		// New position after this character
		if (end_of_input) begin
			nl = line_q;
			nc = col_inc;
		end else if (char_code == stok_pkg::CH_LF) begin
			nl = line_inc;
			nc = POSITION_WIDTH'(1);
		end else begin
			nl = line_q;
			nc = col_inc;
		end

		pend_tok = '{kind: pend_k, begin_line: 16'(sline_q), begin_column: 16'(scol_q),
			end_line: 16'(nl), end_column: 16'(nc), length: tlen_q, last: 1'b0};
		eof_tok  = '{kind: stok_pkg::KIND_EOF, begin_line: 16'(nl), begin_column: 16'(nc),
			end_line: 16'(nl), end_column: 16'(nc), length: 16'd0, last: 1'b1};

		// Does the character extend the pending token
		ext      = 1'b0;
		ext_mode = mode_q;
		unique case (mode_q)
			MODE_INT: begin
				if (is_digit) begin
					ext = 1'b1;
				end else if (char_code == ".") begin
					ext      = 1'b1;
					ext_mode = MODE_DEC;
				end
			end
			MODE_DEC:  ext = is_digit;
			MODE_WORD: ext = is_word;
			MODE_PAIR: begin
				if (pv && (pp.second == char_code)) begin
					ext      = 1'b1;
					ext_mode = MODE_DONE;
				end
			end
			default: ext = 1'b0;
		endcase

		if (step) begin
			line_d = nl;
			col_d  = nc;
			if (end_of_input) begin
				// Flush the pending token, then eof
				if (mode_q != MODE_IDLE) begin
					res.count  = 2'd2;
					res.first  = pend_tok;
					res.second = eof_tok;
				end else begin
					res.count = 2'd1;
					res.first = eof_tok;
				end
				mode_d = MODE_IDLE;
				pend_d = 4'd0;
				tlen_d = 16'd0;
				wlen_d = '0;
			end else if ((mode_q != MODE_IDLE) && ext) begin
				// Grow the pending token
				mode_d = ext_mode;
				if (mode_q == MODE_PAIR) begin
					held_d = pp.both;
					pend_d = 4'd0;
				end
				if ((mode_q == MODE_WORD) && (wlen_q < WLEN_W'(KEYWORD_MAX_LEN))) begin
					pw_en   = 1'b1;
					pw_addr = wlen_q[WIDX_W-1:0];
					wlen_d  = wlen_q + 1'b1;
				end
				tlen_d = (tlen_q != stok_pkg::LEN_MAX) ? tlen_q + 16'd1 : tlen_q;
			end else begin
				// Close the pending token, if any, and start a new one
				if (mode_q != MODE_IDLE) begin
					res.count      = 2'd1;
					res.first      = pend_tok;
					res.first.last = 1'b1;
				end
				if (is_space) begin
					mode_d = MODE_IDLE;
				end else begin
					sline_d = nl;
					scol_d  = nc;
					tlen_d  = 16'd1;
					pend_d  = 4'd0;
					if (is_digit) begin
						mode_d = MODE_INT;
					end else if (is_alpha) begin
						mode_d  = MODE_WORD;
						pw_en   = 1'b1;
						pw_addr = '0;
						wlen_d  = WLEN_W'(1);
					end else if (ph.hit) begin
						mode_d = MODE_PAIR;
						pend_d = {1'b0, ph.idx} + 4'd1;
					end else begin
						mode_d = MODE_DONE;
						held_d = stok_pkg::single_kind(char_code);
					end
				end
			end
		end
	end

	// Hold lexer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pend_q  <= 4'd0;
			held_q  <= stok_pkg::KIND_UNKNOWN;
			wlen_q  <= '0;
			line_q  <= POSITION_WIDTH'(1);
			col_q   <= '0;
			sline_q <= POSITION_WIDTH'(1);
			scol_q  <= '0;
			tlen_q  <= 16'd0;
		end else begin
			mode_q  <= mode_d;
			pend_q  <= pend_d;
			held_q  <= held_d;
			wlen_q  <= wlen_d;
			line_q  <= line_d;
			col_q   <= col_d;
			sline_q <= sline_d;
			scol_q  <= scol_d;
			tlen_q  <= tlen_d;
		end
	end

	// Store word characters for keyword matching
	always_ff @(posedge clk) begin
		if (pw_en)
			prefix_q[pw_addr] <= char_code;
	end

endmodule

[rtl/core/stok_fifo.sv]
`timescale 1ns / 1ps
// Three-entry token buffer between the lexer and the output stream.
// Depends on stok_pkg for token_t and lex_out_t.
module stok_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  stok_pkg::lex_out_t push,
	output logic               room,
	output stok_pkg::token_t   head,
	output logic               head_valid,
	input  logic               head_ready
);

	localparam logic [1:0] LAST_SLOT = 2'd2;

	stok_pkg::token_t ent_q [3];
	logic [1:0]       head_q, tail_q, count_q;
	logic             pop;

	function automatic logic [1:0] slot_inc(input logic [1:0] p);
		return (p == LAST_SLOT) ? 2'd0 : p + 2'd1;
	endfunction

	assign head_valid = (count_q != 2'd0);
	assign head       = ent_q[head_q];
	assign pop        = head_valid && head_ready;
	// Room for the two tokens one transfer may bring
	assign room       = (count_q <= 2'd1);

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= 2'd0;
			tail_q  <= 2'd0;
			count_q <= 2'd0;
		end else begin
			if (pop)
				head_q <= slot_inc(head_q);
			if (push.count == 2'd1)
				tail_q <= slot_inc(tail_q);
			else if (push.count == 2'd2)
				tail_q <= slot_inc(slot_inc(tail_q));
			count_q <= count_q + push.count - {1'b0, pop};
		end
	end

	// Write incoming tokens at the tail
	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			ent_q[tail_q] <= push.first;
		if (push.count == 2'd2)
			ent_q[slot_inc(tail_q)] <= push.second;
	end

endmodule

[rtl/core/source_tokenizer.sv]
`timescale 1ns / 1ps
// Source tokenizer top level: one ASCII character per transfer in, tokens out.
// Depends on stok_pkg, stok_lexer and stok_fifo.
//
// Usage:
//   Input stream: s_tdata carries one character, s_tuser marks end of input
//   (the character is then ignored). Output stream: m_tdata carries one token
//   with its kind, begin and end positions and length; m_tlast flags the final
//   token caused by one input transfer.
//   A token is emitted when the character after it arrives, so with an empty
//   buffer its result shows up on m_tvalid the cycle after that character's
//   transfer. End of input flushes the pending token and then sends eof.
//   Throughput: one character per cycle while tokens drain as they come.
//   s_tready is high while at most one token waits in the three-entry output
//   buffer, room for the two tokens one transfer may produce; once two or more
//   wait (after end of input with a pending token, for example) it drops, and
//   after a stall it returns the cycle after a token is taken that leaves at
//   most one waiting.
//   Reset: lexer idle, line 1, column 0, output buffer empty. While m_tready
//   stays low, tokens collect in the buffer and s_tready drops once two wait.
module source_tokenizer #(
	parameter int KEYWORD_MAX_LEN = 6,
	parameter int POSITION_WIDTH  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] char_code
	input  logic        s_tuser,  // [0] end_of_input
	output logic        m_tvalid,
	input  logic        m_tready,
	// [5:0] token_kind, [21:6] begin_line, [37:22] begin_column,
	// [53:38] end_line, [69:54] end_column, [85:70] token_length, [87:86] zero
	output logic [87:0] m_tdata,
	output logic        m_tlast   // last_of_run
);

	stok_pkg::lex_out_t lex_res;
	stok_pkg::token_t   tok;
	logic               step;

	// Take a character when the buffer has room
	assign step = s_tvalid && s_tready;

	stok_lexer #(
		.KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
		.POSITION_WIDTH  (POSITION_WIDTH)
	) u_lexer (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.char_code    (s_tdata),
		.end_of_input (s_tuser),
		.res          (lex_res)
	);

	stok_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (lex_res),
		.room       (s_tready),
		.head       (tok),
		.head_valid (m_tvalid),
		.head_ready (m_tready)
	);

	// Pack the head token for the output transfer
	assign m_tdata = {2'b00, tok.length, tok.end_column, tok.end_line,
		tok.begin_column, tok.begin_line, tok.kind};
	assign m_tlast = tok.last;

endmodule
